[rtl/core/ordered_list_engine_core_assert.svh]
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OLEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list engine: assertion failed");

// Next-cycle implication, checked outside reset.
`define OLEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list engine: assertion failed");

`endif

[rtl/core/olec_pkg.sv]
// Package with the codes, types and defaults of the ordered list engine.
`default_nettype none

package olec_pkg;

    // Default number of list entries.
    localparam int CAPACITY_DEF = 16;

    // Operation modes carried by an input transaction.
    localparam logic [2:0] MODE_CLEAR      = 3'd0;
    localparam logic [2:0] MODE_INS_FRONT  = 3'd1;
    localparam logic [2:0] MODE_INS_BACK   = 3'd2;
    localparam logic [2:0] MODE_RM_FRONT   = 3'd3;
    localparam logic [2:0] MODE_RM_BACK    = 3'd4;
    localparam logic [2:0] MODE_LOOKUP     = 3'd5;
    localparam logic [2:0] MODE_LOOKUP_RM  = 3'd6;

    // Result status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // Commands broadcast to every cell of the row.
    localparam logic [2:0] CELL_HOLD        = 3'd0;
    localparam logic [2:0] CELL_SHIFT_RIGHT = 3'd1;
    localparam logic [2:0] CELL_SHIFT_LEFT  = 3'd2;
    localparam logic [2:0] CELL_APPEND      = 3'd3;
    localparam logic [2:0] CELL_COMPARE     = 3'd4;
    localparam logic [2:0] CELL_CLOSE_GAP   = 3'd5;

    // Command and operand shared by all cells.
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/ordered_list_engine_core.sv]
// Ordered list engine: insert, remove and search over a row of entry cells.
// Clear, insert and remove transactions give a valid result in the cycle after acceptance.
// Lookups first latch a compare in every cell, then encode the first hit in the search state.
// Throughput is one transaction per cycle, but the search phase of a lookup and a full
// output register hold off the next input transaction.
// Reset (rst_n low, asynchronous) empties the list and the output; entries are not cleared.
`default_nettype none

`include "ordered_list_engine_core_assert.svh"

module ordered_list_engine_core #(
    parameter int CAPACITY = olec_pkg::CAPACITY_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // Input stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [2:0] mode, [34:3] value, [39:35] zero
    // Result stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [6:2] entry_count,
                                   // [10:7] match_position, [15:11] zero
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int POS_W = $clog2(CAPACITY);

    // Controller states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SRCH = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic                remove_reg;
    logic                remove_next;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [15:0]         m_tdata_reg;
    logic [15:0]         m_tdata_next;

    logic                accept;
    logic [2:0]          in_mode;
    logic [31:0]         in_value;
    logic                list_full;
    logic                list_empty;
    logic                out_load;
    logic [1:0]          res_status;
    logic [POS_W-1:0]    res_pos;

    olec_pkg::cell_ctl_t ctl;
    logic [31:0]         entry_w [CAPACITY];
    logic [CAPACITY:0]   seen_w;
    logic [CAPACITY-1:0] first_hit_w;
    logic [POS_W-1:0]    hit_pos;
    logic [31:0]         count_wide;
    logic [31:0]         pos_wide;

    // Handshake and payload unpacking.
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign in_mode  = s_tdata[2:0];
    assign in_value = s_tdata[34:3];

    assign list_full  = (len_reg == LEN_W'(CAPACITY));
    assign list_empty = (len_reg == '0);

    // The row of cells. Each cell sees its two neighbors; the front cell takes the
    // inserted value on a shift toward the back. The match flag ripples from front
    // to back so that only the first matching cell reports a hit.
    assign seen_w[0] = 1'b0;

    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic [31:0] prev_w;
        logic [31:0] next_w;

        if (gi == 0)
        begin : g_front
            assign prev_w = ctl.value;
        end
        else
        begin : g_mid_prev
            assign prev_w = entry_w[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_back
            assign next_w = 32'd0;
        end
        else
        begin : g_mid_next
            assign next_w = entry_w[gi+1];
        end

        olec_cell #(
            .INDEX (gi),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .length     (len_reg),
            .prev_entry (prev_w),
            .next_entry (next_w),
            .seen_in    (seen_w[gi]),
            .entry      (entry_w[gi]),
            .seen_out   (seen_w[gi+1]),
            .first_hit  (first_hit_w[gi])
        );
    end

    // At most one cell reports the first hit, so OR-ing the indices encodes it.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_hit_w[i])
            begin
                hit_pos = hit_pos | POS_W'(i);
            end
        end
    end

    // Main control. Most modes finish in the cycle of acceptance. Lookups first
    // latch a compare result in every cell and finish in the search state.
    always_comb
    begin
        state_next  = state_reg;
        remove_next = remove_reg;
        len_next    = len_reg;
        ctl.op      = olec_pkg::CELL_HOLD;
        ctl.value   = in_value;
        out_load    = 1'b0;
        res_status  = olec_pkg::STATUS_OK;
        res_pos     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_load = 1'b1;
                    case (in_mode)
                        olec_pkg::MODE_CLEAR:
                        begin
                            len_next = '0;
                        end
                        olec_pkg::MODE_INS_FRONT:
                        begin
                            if (list_full)
                            begin
                                res_status = olec_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctl.op   = olec_pkg::CELL_SHIFT_RIGHT;
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        olec_pkg::MODE_INS_BACK:
                        begin
                            if (list_full)
                            begin
                                res_status = olec_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctl.op   = olec_pkg::CELL_APPEND;
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        olec_pkg::MODE_RM_FRONT:
                        begin
                            if (list_empty)
                            begin
                                res_status = olec_pkg::STATUS_MISS;
                            end
                            else
                            begin
                                ctl.op   = olec_pkg::CELL_SHIFT_LEFT;
                                len_next = len_reg - LEN_W'(1);
                            end
                        end
                        olec_pkg::MODE_RM_BACK:
                        begin
                            if (list_empty)
                            begin
                                res_status = olec_pkg::STATUS_MISS;
                            end
                            else
                            begin
                                len_next = len_reg - LEN_W'(1);
                            end
                        end
                        olec_pkg::MODE_LOOKUP, olec_pkg::MODE_LOOKUP_RM:
                        begin
                            out_load    = 1'b0;
                            ctl.op      = olec_pkg::CELL_COMPARE;
                            remove_next = (in_mode == olec_pkg::MODE_LOOKUP_RM);
                            state_next  = ST_SRCH;
                        end
                        default:
                        begin
                            res_status = olec_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SRCH:
            begin
                // The output register was free when the lookup was accepted.
                out_load   = 1'b1;
                state_next = ST_IDLE;
                if (seen_w[CAPACITY])
                begin
                    res_pos = hit_pos;
                    if (remove_reg)
                    begin
                        ctl.op   = olec_pkg::CELL_CLOSE_GAP;
                        len_next = len_reg - LEN_W'(1);
                    end
                end
                else
                begin
                    res_status = olec_pkg::STATUS_MISS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The reported fields keep only their low bits when the list is larger.
    assign count_wide = 32'(len_next);
    assign pos_wide   = 32'(res_pos);

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, pos_wide[3:0], count_wide[4:0], res_status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            remove_reg   <= 1'b0;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            remove_reg   <= remove_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The length never grows past the number of cells.
    `OLEC_ASSERT_IMPLY(a_len_bound, clk, rst_n, 1'b1, len_reg <= LEN_W'(CAPACITY))
    // The search phase always finds the output register empty.
    `OLEC_ASSERT_IMPLY(a_srch_out_free, clk, rst_n, state_reg == ST_SRCH, !m_tvalid_reg)
    // An accepted lookup moves to the search phase with no result yet.
    `OLEC_ASSERT_NEXT(a_lookup_srch, clk, rst_n,
        accept && (in_mode == olec_pkg::MODE_LOOKUP || in_mode == olec_pkg::MODE_LOOKUP_RM),
        state_reg == ST_SRCH && !m_tvalid_reg)
    // The ripple through the cells leaves at most one first hit.
    `OLEC_ASSERT_IMPLY(a_one_hit, clk, rst_n, state_reg == ST_SRCH, $onehot0(first_hit_w))

endmodule

`default_nettype wire

[rtl/core/olec_cell.sv]
// One storage cell of the list row: an entry, its compare and its shift muxes.
`default_nettype none

module olec_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 5
) (
    input  wire                clk,
    input  olec_pkg::cell_ctl_t ctl,
    input  wire [LEN_W-1:0]    length,
    input  wire [31:0]         prev_entry,
    input  wire [31:0]         next_entry,
    input  wire                seen_in,
    output logic [31:0]        entry,
    output logic               seen_out,
    output logic               first_hit
);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    logic        match_reg;
    logic        match_next;
    logic        in_use;

    // The cell holds a live entry when its place is below the list length.
    assign in_use = (LEN_W'(INDEX) < length);

    // A cell at or behind the first match has seen a match.
    assign seen_out  = seen_in | match_reg;
    assign first_hit = match_reg & ~seen_in;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (ctl.op)
            olec_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            olec_pkg::CELL_SHIFT_RIGHT:
            begin
                entry_next = prev_entry;
            end
            olec_pkg::CELL_SHIFT_LEFT:
            begin
                entry_next = next_entry;
            end
            olec_pkg::CELL_APPEND:
            begin
                if (length == LEN_W'(INDEX))
                begin
                    entry_next = ctl.value;
                end
            end
            olec_pkg::CELL_COMPARE:
            begin
                match_next = in_use && (entry_reg == ctl.value);
            end
            olec_pkg::CELL_CLOSE_GAP:
            begin
                if (seen_out)
                begin
                    entry_next = next_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

endmodule

`default_nettype wire

[test/ordered_list_engine_core_tb.sv]
// Self-checking testbench for the ordered list engine: random stream traffic against a list model.
`timescale 1ns / 100ps

module ordered_list_engine_core_tb;

    localparam int CAP = olec_pkg::CAPACITY_DEF;

    // Mode 7 has no operation behind it; the engine only reports the count.
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    // Minimum number of random transactions after the directed opening; a burst may run past it.
    localparam int RANDOM_ITEMS = 660;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
    } list_req_t;

    // Packed from the top bit down, so the layout matches m_tdata[10:0].
    typedef struct packed {
        logic [3:0] match_position;
        logic [4:0] entry_count;
        logic [1:0] status;
    } list_resp_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;

    // Transactions waiting to be driven, and responses predicted but not yet seen.
    list_req_t  pending_q[$];
    list_resp_t expected_q[$];

    // Model of the list held by the engine. Entry 0 is the front.
    logic [31:0] model_entries[CAP];
    int unsigned model_len = 0;

    logic [31:0] value_pool[8];
    int          send_gap   = 0;
    int          recv_gap   = 0;
    int          error_count = 0;
    list_req_t   next_req;
    list_req_t   accepted_req;
    list_resp_t  seen_resp;
    list_resp_t  want_resp;

    ordered_list_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // Apply one operation to the list model and return the response it should produce.
    function automatic list_resp_t apply_list_op(list_req_t req);
        list_resp_t  resp;
        int unsigned hit;
        resp.status = olec_pkg::STATUS_OK;
        hit = 0;
        case (req.mode)
            olec_pkg::MODE_CLEAR: model_len = 0;
            olec_pkg::MODE_INS_FRONT:
                if (model_len >= CAP) begin
                    resp.status = olec_pkg::STATUS_FULL;
                end else begin
                    for (int i = model_len; i > 0; i--)
                        model_entries[i] = model_entries[i - 1];
                    model_entries[0] = req.value;
                    model_len++;
                end
            olec_pkg::MODE_INS_BACK:
                if (model_len >= CAP) begin
                    resp.status = olec_pkg::STATUS_FULL;
                end else begin
                    model_entries[model_len] = req.value;
                    model_len++;
                end
            olec_pkg::MODE_RM_FRONT, olec_pkg::MODE_RM_BACK:
                if (model_len == 0) begin
                    resp.status = olec_pkg::STATUS_MISS;
                end else begin
                    // Removing the front moves every later entry up one place.
                    if (req.mode == olec_pkg::MODE_RM_FRONT)
                        for (int i = 0; i + 1 < model_len; i++)
                            model_entries[i] = model_entries[i + 1];
                    model_len--;
                end
            olec_pkg::MODE_LOOKUP, olec_pkg::MODE_LOOKUP_RM: begin
                hit = model_len;
                for (int i = model_len - 1; i >= 0; i--)
                    if (model_entries[i] == req.value)
                        hit = i;
                if (hit >= model_len) begin
                    resp.status = olec_pkg::STATUS_MISS;
                    hit = 0;
                end else if (req.mode == olec_pkg::MODE_LOOKUP_RM) begin
                    for (int i = hit; i + 1 < model_len; i++)
                        model_entries[i] = model_entries[i + 1];
                    model_len--;
                end
            end
            default: ;
        endcase
        resp.entry_count    = model_len[4:0];
        resp.match_position = hit[3:0];
        return resp;
    endfunction

    // Idle bursts are allowed in two of every three stretches of the queue, and never near the end of the run.
    function automatic bit idling_allowed();
        return pending_q.size() > 80 && (pending_q.size() / 50) % 3 != 0;
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 7)];
    endfunction

    task automatic add_item(logic [2:0] mode, logic [31:0] value);
        list_req_t req;
        req.mode  = mode;
        req.value = value;
        pending_q.push_back(req);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Driver: a transaction is predicted at the edge where it is accepted, then the
    // next one from the pending queue is presented, unless an idle burst is running.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                accepted_req.mode  = s_tdata[2:0];
                accepted_req.value = s_tdata[34:3];
                expected_q.push_back(apply_list_op(accepted_req));
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end else begin
                next_req = pending_q.pop_front();
                s_tdata  <= {5'b0, next_req.value, next_req.mode};
                s_tvalid <= 1'b1;
            end
        end
    end

    // Monitor: every accepted response is checked against the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_resp = m_tdata[10:0];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected response, actual %h", $time, m_tdata);
                    error_count++;
                end else begin
                    want_resp = expected_q.pop_front();
                    check_field("status", want_resp.status, seen_resp.status);
                    check_field("entry_count", want_resp.entry_count, seen_resp.entry_count);
                    check_field("match_position", want_resp.match_position,
                                seen_resp.match_position);
                end
                if (m_tdata[15:11] != '0) begin
                    $display("%0t: mismatch in padding: expected 0, actual %h",
                             $time, m_tdata[15:11]);
                    error_count++;
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int n;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // Operations on an empty list, and the unused mode.
        add_item(olec_pkg::MODE_RM_FRONT, 32'h0);
        add_item(olec_pkg::MODE_RM_BACK, 32'hFFFF_FFFF);
        add_item(olec_pkg::MODE_LOOKUP, 32'h0);
        add_item(olec_pkg::MODE_LOOKUP_RM, 32'h0);
        add_item(MODE_UNUSED, 32'h5555_5555);
        // Build a list holding the extreme values: -1, min, max, 0.
        add_item(olec_pkg::MODE_INS_FRONT, 32'h8000_0000);
        add_item(olec_pkg::MODE_INS_BACK, 32'h7FFF_FFFF);
        add_item(olec_pkg::MODE_INS_BACK, 32'h0000_0000);
        add_item(olec_pkg::MODE_INS_FRONT, 32'hFFFF_FFFF);
        add_item(MODE_UNUSED, 32'hAAAA_AAAA);
        add_item(olec_pkg::MODE_LOOKUP, 32'h7FFF_FFFF);
        add_item(olec_pkg::MODE_LOOKUP, 32'h0000_3039);
        add_item(olec_pkg::MODE_LOOKUP_RM, 32'h0000_3039);
        // A match at the head is removed like any other; then the tail.
        add_item(olec_pkg::MODE_LOOKUP_RM, 32'hFFFF_FFFF);
        add_item(olec_pkg::MODE_LOOKUP_RM, 32'h0000_0000);
        add_item(olec_pkg::MODE_RM_BACK, 32'h0);
        add_item(olec_pkg::MODE_RM_FRONT, 32'h0);
        // Fill to capacity, overflow at both ends, then clear a full list.
        for (int i = 0; i < CAP; i++)
            add_item(olec_pkg::MODE_INS_BACK, i);
        add_item(olec_pkg::MODE_INS_FRONT, 32'h1234_5678);
        add_item(olec_pkg::MODE_INS_BACK, 32'h1234_5678);
        add_item(olec_pkg::MODE_LOOKUP, CAP - 1);
        add_item(olec_pkg::MODE_CLEAR, 32'hFFFF_FFFF);

        // Random part: mostly fill runs and searches over a small value pool, so the
        // list often reaches capacity and lookups hit at many positions.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    repeat ($urandom_range(1, 18)) begin
                        add_item($urandom_range(0, 1) ? olec_pkg::MODE_INS_FRONT
                                                      : olec_pkg::MODE_INS_BACK,
                                 pick_value());
                        n++;
                    end
                8, 9, 10, 11, 12:
                    repeat ($urandom_range(1, 6)) begin
                        add_item($urandom_range(0, 1) ? olec_pkg::MODE_LOOKUP
                                                      : olec_pkg::MODE_LOOKUP_RM,
                                 pick_value());
                        n++;
                    end
                13, 14, 15:
                    repeat ($urandom_range(1, 6)) begin
                        add_item($urandom_range(0, 1) ? olec_pkg::MODE_RM_FRONT
                                                      : olec_pkg::MODE_RM_BACK,
                                 $urandom);
                        n++;
                    end
                16, 17, 18: begin
                    add_item(3'($urandom_range(0, 7)), $urandom);
                    n++;
                end
                default: begin
                    add_item(olec_pkg::MODE_CLEAR, $urandom);
                    n++;
                end
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every transaction has been accepted, then until all responses are in.
        do
            @(posedge clk);
        while (pending_q.size() != 0 || s_tvalid);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0 && expected_q.size() == 0) begin
            $display("** ordered_list_engine_core: PASSED **");
        end else begin
            if (expected_q.size() != 0)
                $display("%0t: %0d expected responses never arrived", $time, expected_q.size());
            $display("** ordered_list_engine_core: FAILED **");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("** ordered_list_engine_core: FAILED **");
        $finish;
    end

endmodule
